// ===== hdl/rbs_pkg.sv =====
// Package for the rigid body bounce/sleep stepper.
// Types, register indexes, reset values and fixed-point helpers.
// No dependencies.
package rbs_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_GRAVITY  = 3'd0;
  localparam logic [2:0] CFG_STEP     = 3'd1;
  localparam logic [2:0] CFG_FRICTION = 3'd2;
  localparam logic [2:0] CFG_RESTIT   = 3'd3;
  localparam logic [2:0] CFG_SPIN     = 3'd4;
  localparam logic [2:0] CFG_LIN_LIM  = 3'd5;
  localparam logic [2:0] CFG_ANG_LIM  = 3'd6;
  localparam logic [2:0] CFG_SETTLE   = 3'd7;

  localparam logic [19:0] GRAVITY_RST  = 20'd10716;
  localparam logic [15:0] STEP_RST     = 16'd1092;
  localparam logic [15:0] FRICTION_RST = 16'd56361;
  localparam logic [15:0] RESTIT_RST   = 16'd14418;
  localparam logic [15:0] SPIN_RST     = 16'd47186;
  localparam logic [15:0] LIN_LIM_RST  = 16'd2621;
  localparam logic [15:0] ANG_LIM_RST  = 16'd1966;
  localparam logic [7:0]  SETTLE_RST   = 8'd30;

  localparam logic        CMD_SPAWN = 1'b0;
  localparam logic        CMD_TICK  = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [19:0] gravity;
    logic [15:0] step;
    logic [15:0] friction;
    logic [15:0] restit;
    logic [15:0] spin;
    logic [15:0] lin_lim;
    logic [15:0] ang_lim;
    logic [7:0]  settle;
  } rbs_cfg_t;

  typedef struct packed {
    logic            cmd;
    logic [63:0]     body_id;
    logic [2:0][31:0] pos;
    logic [30:0]     half_height;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] spin;
  } rbs_item_t;

  typedef struct packed {
    logic [63:0]      id;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] spin;
    logic [30:0]      half_height;
    logic [7:0]       quiet;
  } rbs_body_t;

  typedef struct packed {
    logic [63:0]      id;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] spin;
    logic             settled;
    logic             last;
  } rbs_res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SP_RD, ST_SP_CMP, ST_SP_WR, ST_TK_RD, ST_TK_LOAD, ST_TK_OP, ST_TK_FIN
  } rbs_state_e;

  // micro-operations of one body update, in order
  typedef enum logic [4:0] {
    OP_GRAV, OP_PX, OP_PY, OP_PZ, OP_CONTACT, OP_FVX, OP_FVZ, OP_BVY,
    OP_WX, OP_WY, OP_WZ, OP_LX, OP_LY, OP_LZ, OP_AX, OP_AY, OP_AZ
  } rbs_op_e;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > S32_MAX) begin
      r = 32'h7fff_ffff;
    end else if (v < S32_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q16 product back to Q16.16: round half up, then saturate
  function automatic logic [31:0] qround(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = (p + 66'sd32768) >>> 16;
    return sat32(t);
  endfunction

endpackage

// ===== hdl/rbs_front.sv =====
// Front end: accepts input beats, drops spawns with id zero, queues the rest.
// Depends on rbs_pkg.
module rbs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rbs_pkg::rbs_item_t  item_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output rbs_pkg::rbs_item_t  q_item_o
);

  rbs_pkg::rbs_item_t buf_q [rbs_pkg::QUEUE_DEPTH];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop, keep;

  // spawns with id zero are swallowed here
  assign keep       = (item_i.cmd == rbs_pkg::CMD_TICK) || (item_i.body_id != 64'd0);
  assign in_stall_o = (cnt_q == 2'(rbs_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o && keep;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rptr_q];

  always_comb begin
    wptr_d = push ? !wptr_q : wptr_q;
    rptr_d = pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/rbs_back.sv =====
// Back end: body table in memory, spawn lookup sweep and per-body tick
// sequencer around one shared 33x33 multiplier. Depends on rbs_pkg.
module rbs_back #(
  parameter int unsigned MAX_BODIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbs_pkg::rbs_cfg_t  cfg_i,
  input  logic               q_valid_i,
  input  rbs_pkg::rbs_item_t q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rbs_pkg::rbs_res_t  res_o
);

  localparam int unsigned SW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int unsigned CW = $clog2(MAX_BODIES + 1);

  rbs_pkg::rbs_state_e state_q, state_d;
  rbs_pkg::rbs_op_e    op_q, op_d;
  logic                phase_q, phase_d;
  logic [CW-1:0]       slot_q, slot_d;
  logic [SW-1:0]       tgt_q, tgt_d, free_q, free_d, sidx;
  logic                free_ok_q, free_ok_d;
  logic [MAX_BODIES-1:0] valid_q, valid_d;
  rbs_pkg::rbs_item_t  item_q, item_d;
  rbs_pkg::rbs_body_t  work_q, work_d, rdata_q, wdata;
  logic signed [65:0]  mul_q, mul_d, prod;
  logic [63:0]         lacc_q, lacc_d, aacc_q, aacc_d;
  logic [31:0]         llim_q, alim_q;
  logic                out_valid_q, out_valid_d;
  rbs_pkg::rbs_res_t   res_q, res_d;
  logic                we;
  logic [SW-1:0]       waddr;
  logic signed [32:0]  op_a, op_b;
  logic [31:0]         qr;
  logic                slot_end, out_free, need_mul, later, quiet, done;
  logic [7:0]          qt_new;

  rbs_pkg::rbs_body_t mem [MAX_BODIES];

  assign sidx     = slot_q[SW-1:0];
  assign slot_end = (slot_q == CW'(MAX_BODIES));
  assign out_free = !out_valid_q || !out_stall_i;
  assign qr       = rbs_pkg::qround(mul_q);
  assign prod     = op_a * op_b;
  assign need_mul = (op_q != rbs_pkg::OP_GRAV) && (op_q != rbs_pkg::OP_CONTACT);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // any valid body after the current slot
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < MAX_BODIES; i++) begin
      if (valid_q[i] && (CW'(i) > slot_q)) later = 1'b1;
    end
  end

  // quiet test and count update
  always_comb begin
    quiet  = (lacc_q < {32'd0, llim_q}) && (aacc_q < {32'd0, alim_q});
    qt_new = quiet ? ((work_q.quiet == 8'hff) ? 8'hff : work_q.quiet + 8'd1) : 8'd0;
    done   = (qt_new >= cfg_i.settle);
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (op_q)
      rbs_pkg::OP_PX, rbs_pkg::OP_PY, rbs_pkg::OP_PZ: begin
        op_a = 33'($signed(work_q.vel[2'(op_q - rbs_pkg::OP_PX)]));
        op_b = 33'(cfg_i.step);
      end
      rbs_pkg::OP_FVX: begin
        op_a = 33'($signed(work_q.vel[0]));
        op_b = 33'(cfg_i.friction);
      end
      rbs_pkg::OP_FVZ: begin
        op_a = 33'($signed(work_q.vel[2]));
        op_b = 33'(cfg_i.friction);
      end
      rbs_pkg::OP_BVY: begin
        op_a = work_q.vel[1][31] ? -33'($signed(work_q.vel[1]))
                                 : 33'($signed(work_q.vel[1]));
        op_b = 33'(cfg_i.restit);
      end
      rbs_pkg::OP_WX, rbs_pkg::OP_WY, rbs_pkg::OP_WZ: begin
        op_a = 33'($signed(work_q.spin[2'(op_q - rbs_pkg::OP_WX)]));
        op_b = 33'(cfg_i.spin);
      end
      rbs_pkg::OP_LX, rbs_pkg::OP_LY, rbs_pkg::OP_LZ: begin
        op_a = 33'($signed(work_q.vel[2'(op_q - rbs_pkg::OP_LX)]));
        op_b = op_a;
      end
      rbs_pkg::OP_AX, rbs_pkg::OP_AY, rbs_pkg::OP_AZ: begin
        op_a = 33'($signed(work_q.spin[2'(op_q - rbs_pkg::OP_AX)]));
        op_b = op_a;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    phase_d     = phase_q;
    slot_d      = slot_q;
    tgt_d       = tgt_q;
    free_d      = free_q;
    free_ok_d   = free_ok_q;
    valid_d     = valid_q;
    item_d      = item_q;
    work_d      = work_q;
    mul_d       = mul_q;
    lacc_d      = lacc_q;
    aacc_d      = aacc_q;
    res_d       = res_q;
    out_valid_d = (out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    waddr       = sidx;
    wdata       = work_q;

    unique case (state_q)
      rbs_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          item_d    = q_item_i;
          slot_d    = '0;
          free_ok_d = 1'b0;
          state_d   = (q_item_i.cmd == rbs_pkg::CMD_TICK) ? rbs_pkg::ST_TK_RD
                                                          : rbs_pkg::ST_SP_RD;
        end
      end

      // spawn: sweep for matching id, remember first free slot
      rbs_pkg::ST_SP_RD: begin
        if (slot_end) begin
          if (free_ok_q) begin
            tgt_d   = free_q;
            state_d = rbs_pkg::ST_SP_WR;
          end else begin
            state_d = rbs_pkg::ST_IDLE;
          end
        end else if (valid_q[sidx]) begin
          state_d = rbs_pkg::ST_SP_CMP;
        end else begin
          if (!free_ok_q) begin
            free_ok_d = 1'b1;
            free_d    = sidx;
          end
          slot_d = slot_q + CW'(1);
        end
      end

      rbs_pkg::ST_SP_CMP: begin
        if (rdata_q.id == item_q.body_id) begin
          tgt_d   = sidx;
          state_d = rbs_pkg::ST_SP_WR;
        end else begin
          slot_d  = slot_q + CW'(1);
          state_d = rbs_pkg::ST_SP_RD;
        end
      end

      rbs_pkg::ST_SP_WR: begin
        we                = 1'b1;
        waddr             = tgt_q;
        wdata.id          = item_q.body_id;
        wdata.pos         = item_q.pos;
        wdata.vel         = item_q.vel;
        wdata.spin        = item_q.spin;
        wdata.half_height = item_q.half_height;
        wdata.quiet       = 8'd0;
        valid_d[tgt_q]    = 1'b1;
        state_d           = rbs_pkg::ST_IDLE;
      end

      // tick: walk slots in order
      rbs_pkg::ST_TK_RD: begin
        if (slot_end) begin
          state_d = rbs_pkg::ST_IDLE;
        end else if (valid_q[sidx]) begin
          state_d = rbs_pkg::ST_TK_LOAD;
        end else begin
          slot_d = slot_q + CW'(1);
        end
      end

      rbs_pkg::ST_TK_LOAD: begin
        work_d  = rdata_q;
        op_d    = rbs_pkg::OP_GRAV;
        phase_d = 1'b0;
        lacc_d  = '0;
        aacc_d  = '0;
        state_d = rbs_pkg::ST_TK_OP;
      end

      rbs_pkg::ST_TK_OP: begin
        if (need_mul && !phase_q) begin
          mul_d   = prod;
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          op_d    = rbs_pkg::rbs_op_e'(op_q + 5'd1);
          unique case (op_q)
            rbs_pkg::OP_GRAV:
              work_d.vel[1] = rbs_pkg::sat32(66'($signed(work_q.vel[1])) - 66'(cfg_i.gravity));
            rbs_pkg::OP_PX, rbs_pkg::OP_PY, rbs_pkg::OP_PZ:
              work_d.pos[2'(op_q - rbs_pkg::OP_PX)] = rbs_pkg::sat32(
                66'($signed(work_q.pos[2'(op_q - rbs_pkg::OP_PX)])) + 66'($signed(qr)));
            rbs_pkg::OP_CONTACT: begin
              if ($signed(work_q.pos[1]) <= $signed({1'b0, work_q.half_height})) begin
                work_d.pos[1] = {1'b0, work_q.half_height};
              end else begin
                op_d = rbs_pkg::OP_LX;
              end
            end
            rbs_pkg::OP_FVX: work_d.vel[0] = qr;
            rbs_pkg::OP_FVZ: work_d.vel[2] = qr;
            rbs_pkg::OP_BVY: work_d.vel[1] = qr;
            rbs_pkg::OP_WX, rbs_pkg::OP_WY, rbs_pkg::OP_WZ:
              work_d.spin[2'(op_q - rbs_pkg::OP_WX)] = qr;
            rbs_pkg::OP_LX, rbs_pkg::OP_LY, rbs_pkg::OP_LZ:
              lacc_d = lacc_q + mul_q[63:0];
            rbs_pkg::OP_AX, rbs_pkg::OP_AY: aacc_d = aacc_q + mul_q[63:0];
            rbs_pkg::OP_AZ: begin
              aacc_d  = aacc_q + mul_q[63:0];
              op_d    = rbs_pkg::OP_GRAV;
              state_d = rbs_pkg::ST_TK_FIN;
            end
            default: state_d = rbs_pkg::ST_IDLE;
          endcase
        end
      end

      // report the body, write it back, drop it once settled
      rbs_pkg::ST_TK_FIN: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          res_d.id      = work_q.id;
          res_d.pos     = work_q.pos;
          res_d.vel     = work_q.vel;
          res_d.spin    = work_q.spin;
          res_d.settled = done;
          res_d.last    = !later;
          we            = 1'b1;
          wdata.quiet   = qt_new;
          if (done) valid_d[sidx] = 1'b0;
          slot_d  = slot_q + CW'(1);
          state_d = rbs_pkg::ST_TK_RD;
        end
      end

      default: state_d = rbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbs_pkg::ST_IDLE;
      op_q        <= rbs_pkg::OP_GRAV;
      phase_q     <= 1'b0;
      slot_q      <= '0;
      free_ok_q   <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      phase_q     <= phase_d;
      slot_q      <= slot_d;
      free_ok_q   <= free_ok_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    tgt_q  <= tgt_d;
    free_q <= free_d;
    item_q <= item_d;
    work_q <= work_d;
    mul_q  <= mul_d;
    lacc_q <= lacc_d;
    aacc_q <= aacc_d;
    res_q  <= res_d;
    llim_q <= 32'(cfg_i.lin_lim) * 32'(cfg_i.lin_lim);
    alim_q <= 32'(cfg_i.ang_lim) * 32'(cfg_i.ang_lim);
  end

  // body table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[sidx];
  end

endmodule

// ===== hdl/rigid_body_bounce_sleep_stepper_top.sv =====
// Top level of the rigid body bounce/sleep stepper: config registers,
// front queue and back sequencer. Depends on rbs_pkg, rbs_front, rbs_back.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | cmd_i, body_id_i, start_*_i, half_height_i
//  out     | output    | out_valid_o/out_stall_i | out_id_o, pos_*, vel_*, spin_*, settled, last
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// A spawn sweeps the table: a valid slot passes through SP_RD and SP_CMP, an empty one SP_RD only.
// A tick skips empty slots and runs each valid body through the shared multiplier
// sequence; a body touching the floor adds the friction, bounce and spin steps.
// Reset clears all slot valid bits and the queue; table memory is not swept.
// A stalled output holds the sequencer; the 2-entry input queue keeps accepting until full.
module rigid_body_bounce_sleep_stepper_top #(
  parameter int unsigned MAX_BODIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [63:0]        body_id_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic [30:0]        half_height_i,
  input  logic signed [31:0] start_vx_i,
  input  logic signed [31:0] start_vy_i,
  input  logic signed [31:0] start_vz_i,
  input  logic signed [31:0] start_wx_i,
  input  logic signed [31:0] start_wy_i,
  input  logic signed [31:0] start_wz_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [63:0]        out_id_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_z_o,
  output logic signed [31:0] spin_x_o,
  output logic signed [31:0] spin_y_o,
  output logic signed [31:0] spin_z_o,
  output logic               settled_o,
  output logic               last_body_o
);

  rbs_pkg::rbs_cfg_t  cfg_q;
  rbs_pkg::rbs_item_t in_item, q_item;
  rbs_pkg::rbs_res_t  res;
  logic               q_valid, q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity  <= rbs_pkg::GRAVITY_RST;
      cfg_q.step     <= rbs_pkg::STEP_RST;
      cfg_q.friction <= rbs_pkg::FRICTION_RST;
      cfg_q.restit   <= rbs_pkg::RESTIT_RST;
      cfg_q.spin     <= rbs_pkg::SPIN_RST;
      cfg_q.lin_lim  <= rbs_pkg::LIN_LIM_RST;
      cfg_q.ang_lim  <= rbs_pkg::ANG_LIM_RST;
      cfg_q.settle   <= rbs_pkg::SETTLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbs_pkg::CFG_GRAVITY:  cfg_q.gravity  <= cfg_data_i;
        rbs_pkg::CFG_STEP:     cfg_q.step     <= cfg_data_i[15:0];
        rbs_pkg::CFG_FRICTION: cfg_q.friction <= cfg_data_i[15:0];
        rbs_pkg::CFG_RESTIT:   cfg_q.restit   <= cfg_data_i[15:0];
        rbs_pkg::CFG_SPIN:     cfg_q.spin     <= cfg_data_i[15:0];
        rbs_pkg::CFG_LIN_LIM:  cfg_q.lin_lim  <= cfg_data_i[15:0];
        rbs_pkg::CFG_ANG_LIM:  cfg_q.ang_lim  <= cfg_data_i[15:0];
        rbs_pkg::CFG_SETTLE:   cfg_q.settle   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // pack input beat
  always_comb begin
    in_item.cmd         = cmd_i;
    in_item.body_id     = body_id_i;
    in_item.pos         = {start_z_i, start_y_i, start_x_i};
    in_item.half_height = half_height_i;
    in_item.vel         = {start_vz_i, start_vy_i, start_vx_i};
    in_item.spin        = {start_wz_i, start_wy_i, start_wx_i};
  end

  rbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  rbs_back #(.MAX_BODIES(MAX_BODIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // unpack result beat
  assign out_id_o    = res.id;
  assign pos_x_o     = res.pos[0];
  assign pos_y_o     = res.pos[1];
  assign pos_z_o     = res.pos[2];
  assign vel_x_o     = res.vel[0];
  assign vel_y_o     = res.vel[1];
  assign vel_z_o     = res.vel[2];
  assign spin_x_o    = res.spin[0];
  assign spin_y_o    = res.spin[1];
  assign spin_z_o    = res.spin[2];
  assign settled_o   = res.settled;
  assign last_body_o = res.last;

endmodule

// ===== hdl/rbs_checker.sv =====
// Port-level checks for the stepper, bound to the top level.
// Depends on rigid_body_bounce_sleep_stepper_top ports only.
module rbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] out_id_o,
  input logic        last_body_o
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_id_o) && $stable(last_body_o))
    else $error("stalled output beat changed");

  // no result beat comes out of reset
  a_reset_out: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // input is not stalled while in reset
  a_reset_in: assert property (@(posedge clk_i) !rst_ni |-> !in_stall_o)
    else $error("input stalled during reset");

endmodule

bind rigid_body_bounce_sleep_stepper_top rbs_checker u_rbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_id_o    (out_id_o),
  .last_body_o (last_body_o)
);

// ===== tb/sv/tb_rigid_body_bounce_sleep_stepper_top.sv =====
// Self-checking testbench for rigid_body_bounce_sleep_stepper_top.
// Drives spawn/tick beats, predicts every body report, compares field by field.
// Depends on rbs_pkg and the top level only.
`timescale 1ns / 1ps

module tb_rigid_body_bounce_sleep_stepper_top;

  localparam int NB = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    bit              cmd;
    longint unsigned id;
    int              p[3];
    int unsigned     hh;
    int              v[3];
    int              w[3];
  } body_cmd_t;

  typedef struct {
    longint unsigned id;
    int              p[3];
    int              v[3];
    int              w[3];
    bit              settled;
    bit              last;
  } body_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic [63:0] body_id_i = '0;
  logic signed [31:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic [30:0] half_height_i = '0;
  logic signed [31:0] start_vx_i = '0, start_vy_i = '0, start_vz_i = '0;
  logic signed [31:0] start_wx_i = '0, start_wy_i = '0, start_wz_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [63:0] out_id_o;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o;
  logic signed [31:0] spin_x_o, spin_y_o, spin_z_o;
  logic settled_o, last_body_o;

  rigid_body_bounce_sleep_stepper_top i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: configuration and body table
  int unsigned g_step, dt, fric, restit, spin_damp, lin_lim, ang_lim, settle_n;
  bit              tb_valid[NB];
  longint unsigned tb_id[NB];
  int              tb_p[NB][3], tb_v[NB][3], tb_w[NB][3];
  int              tb_hh[NB];
  int unsigned     tb_quiet[NB];

  body_report_t report_q[$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  idle_en = 1'b1;

  function automatic int clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return int'(x);
  endfunction

  // Q16 scale, round half up, saturate
  function automatic int scale_q16(longint a, int unsigned f);
    longint prod;
    prod = a * longint'(f);
    return clamp32((prod + 64'sd32768) >>> 16);
  endfunction

  function automatic longint unsigned mag_sq(int x, int y, int z);
    longint unsigned s;
    longint unsigned a;
    s = 0;
    a = (x < 0) ? longint'(-longint'(x)) : longint'(x); s += a * a;
    a = (y < 0) ? longint'(-longint'(y)) : longint'(y); s += a * a;
    a = (z < 0) ? longint'(-longint'(z)) : longint'(z); s += a * a;
    return s;
  endfunction

  function automatic void apply_spawn(body_cmd_t c);
    int tgt;
    tgt = -1;
    if (c.id == 0) return;
    for (int s = 0; s < NB; s++)
      if (tgt < 0 && tb_valid[s] && tb_id[s] == c.id) tgt = s;
    for (int s = 0; s < NB; s++)
      if (tgt < 0 && !tb_valid[s]) tgt = s;
    if (tgt < 0) return;
    tb_valid[tgt] = 1'b1;
    tb_id[tgt] = c.id;
    tb_p[tgt] = c.p;
    tb_v[tgt] = c.v;
    tb_w[tgt] = c.w;
    tb_hh[tgt] = int'(c.hh & 32'h7fffffff);
    tb_quiet[tgt] = 0;
  endfunction

  // integrate every body and queue its report
  function automatic void apply_tick();
    int n;
    longint ay;
    bit quiet;
    body_report_t r;
    n = 0;
    for (int s = 0; s < NB; s++) begin
      if (!tb_valid[s]) continue;
      tb_v[s][1] = clamp32(longint'(tb_v[s][1]) - longint'(g_step));
      for (int i = 0; i < 3; i++)
        tb_p[s][i] = clamp32(longint'(tb_p[s][i]) + scale_q16(tb_v[s][i], dt));
      if (tb_p[s][1] <= tb_hh[s]) begin
        ay = (tb_v[s][1] < 0) ? -longint'(tb_v[s][1]) : longint'(tb_v[s][1]);
        tb_p[s][1] = tb_hh[s];
        tb_v[s][0] = scale_q16(tb_v[s][0], fric);
        tb_v[s][2] = scale_q16(tb_v[s][2], fric);
        tb_v[s][1] = scale_q16(ay, restit);
        for (int i = 0; i < 3; i++) tb_w[s][i] = scale_q16(tb_w[s][i], spin_damp);
      end
      quiet = mag_sq(tb_v[s][0], tb_v[s][1], tb_v[s][2]) <
                longint'(lin_lim) * longint'(lin_lim) &&
              mag_sq(tb_w[s][0], tb_w[s][1], tb_w[s][2]) <
                longint'(ang_lim) * longint'(ang_lim);
      if (quiet) begin
        if (tb_quiet[s] < 255) tb_quiet[s]++;
      end else begin
        tb_quiet[s] = 0;
      end
      r.id = tb_id[s];
      r.p = tb_p[s];
      r.v = tb_v[s];
      r.w = tb_w[s];
      r.settled = (tb_quiet[s] >= settle_n);
      r.last = 1'b0;
      report_q = {report_q, r};
      n++;
      if (r.settled) tb_valid[s] = 1'b0;
    end
    if (n > 0) report_q[report_q.size() - 1].last = 1'b1;
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [19:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      rbs_pkg::CFG_GRAVITY:  g_step = data;
      rbs_pkg::CFG_STEP:     dt = data[15:0];
      rbs_pkg::CFG_FRICTION: fric = data[15:0];
      rbs_pkg::CFG_RESTIT:   restit = data[15:0];
      rbs_pkg::CFG_SPIN:     spin_damp = data[15:0];
      rbs_pkg::CFG_LIN_LIM:  lin_lim = data[15:0];
      rbs_pkg::CFG_ANG_LIM:  ang_lim = data[15:0];
      rbs_pkg::CFG_SETTLE:   settle_n = data[7:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [19:0] gr, st, fr, re, sp, ll, al, se);
    cfg_write(rbs_pkg::CFG_GRAVITY, gr);
    cfg_write(rbs_pkg::CFG_STEP, st);
    cfg_write(rbs_pkg::CFG_FRICTION, fr);
    cfg_write(rbs_pkg::CFG_RESTIT, re);
    cfg_write(rbs_pkg::CFG_SPIN, sp);
    cfg_write(rbs_pkg::CFG_LIN_LIM, ll);
    cfg_write(rbs_pkg::CFG_ANG_LIM, al);
    cfg_write(rbs_pkg::CFG_SETTLE, se);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for every report, then for any spawn still sweeping the table
  task automatic drain();
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // send one beat, update the predictor on acceptance, maybe idle afterwards
  task automatic send(body_cmd_t c);
    in_valid_i <= 1'b1;
    cmd_i <= c.cmd;
    body_id_i <= c.id;
    start_x_i <= c.p[0]; start_y_i <= c.p[1]; start_z_i <= c.p[2];
    half_height_i <= c.hh[30:0];
    start_vx_i <= c.v[0]; start_vy_i <= c.v[1]; start_vz_i <= c.v[2];
    start_wx_i <= c.w[0]; start_wy_i <= c.w[1]; start_wz_i <= c.w[2];
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (c.cmd == rbs_pkg::CMD_TICK) apply_tick();
    else apply_spawn(c);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  function automatic body_cmd_t mk(bit cmd, longint unsigned id, int y, int unsigned hh,
                                   int vy, int fill_p, int fill_v, int fill_w);
    body_cmd_t c;
    c.cmd = cmd;
    c.id = id;
    c.p = '{fill_p, y, fill_p};
    c.hh = hh;
    c.v = '{fill_v, vy, fill_v};
    c.w = '{fill_w, fill_w, fill_w};
    return c;
  endfunction

  function automatic int srand(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // random beat: mostly near-floor bodies from a small id pool, some ticks, some noise
  function automatic body_cmd_t rand_beat();
    body_cmd_t c;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    c.cmd = rbs_pkg::CMD_SPAWN;
    c.id = $urandom_range(1, 20);
    c.hh = $urandom_range(0, 131072);
    c.p = '{srand(1 << 20), int'(c.hh) + srand(8192), srand(1 << 20)};
    c.v = '{srand(8192), srand(16384), srand(8192)};
    c.w = '{srand(8192), srand(8192), srand(8192)};
    if (sel < 35) begin
      c.cmd = rbs_pkg::CMD_TICK;
    end else if (sel < 45) begin
      c.id = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) c.id = 0;
      c.hh = $urandom;
      c.p = '{int'($urandom), int'($urandom), int'($urandom)};
      c.v = '{int'($urandom), int'($urandom), int'($urandom)};
      c.w = '{int'($urandom), int'($urandom), int'($urandom)};
      c.cmd = 1'($urandom_range(0, 1));
    end
    return c;
  endfunction

  // output side: random stall bursts, compare each accepted beat
  int stall_left = 0;
  always @(posedge clk_i) begin
    body_report_t e;
    bit bad;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report id=%h", out_id_o);
      end else begin
        e = report_q.pop_front();
        bad = out_id_o != e.id || pos_x_o != e.p[0] || pos_y_o != e.p[1] ||
              pos_z_o != e.p[2] || vel_x_o != e.v[0] || vel_y_o != e.v[1] ||
              vel_z_o != e.v[2] || spin_x_o != e.w[0] || spin_y_o != e.w[1] ||
              spin_z_o != e.w[2] || settled_o != e.settled || last_body_o != e.last;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp id=%h p=%0d,%0d,%0d v=%0d,%0d,%0d w=%0d,%0d,%0d s=%0b l=%0b",
                     e.id, e.p[0], e.p[1], e.p[2], e.v[0], e.v[1], e.v[2],
                     e.w[0], e.w[1], e.w[2], e.settled, e.last);
            $display("         got id=%h p=%0d,%0d,%0d v=%0d,%0d,%0d w=%0d,%0d,%0d s=%0b l=%0b",
                     out_id_o, pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o,
                     spin_x_o, spin_y_o, spin_z_o, settled_o, last_body_o);
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // directed rows: extremes, id zero, replacement, floor contact, empty tick
  body_cmd_t dir_rows[$];

  initial begin
    g_step = rbs_pkg::GRAVITY_RST; dt = rbs_pkg::STEP_RST;
    fric = rbs_pkg::FRICTION_RST; restit = rbs_pkg::RESTIT_RST;
    spin_damp = rbs_pkg::SPIN_RST; lin_lim = rbs_pkg::LIN_LIM_RST;
    ang_lim = rbs_pkg::ANG_LIM_RST;
    settle_n = rbs_pkg::SETTLE_RST;
    foreach (tb_valid[s]) tb_valid[s] = 1'b0;

    dir_rows = {dir_rows, mk(rbs_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_SPAWN, 0, 100, 0, 0, 5, 5, 5)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_SPAWN, 64'd1, 32'sh7fffffff, 31'h7fffffff,
                             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_SPAWN, 64'hffff_ffff_ffff_ffff, 32'sh80000000, 0,
                             32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_SPAWN, 64'd2, 65536, 65536, 0, 0, 100, 50)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_SPAWN, 64'd3, 1 << 24, 1 << 16, -(1 << 20),
                             1000, 300, -200)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_SPAWN, 64'd2, 0, 32768, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_SPAWN, 64'h8000_0000_0000_0000, -5, 0, -70000,
                             -1, -1, -1)};
    dir_rows = {dir_rows, mk(rbs_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, 0)};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings
    foreach (dir_rows[k]) send(dir_rows[k]);
    in_valid_i <= 1'b0;
    drain();

    // all factors at the top, settle on the first quiet tick
    cfg_all(20'hfffff, 20'hffff, 20'hffff, 20'hffff, 20'hffff, 20'hffff, 20'hffff, 20'd1);
    foreach (dir_rows[k]) send(dir_rows[k]);
    in_valid_i <= 1'b0;
    drain();

    // all zero: settle count of zero settles every body at once
    cfg_all(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    for (int k = 0; k < 12; k++) send(rand_beat());
    in_valid_i <= 1'b0;
    drain();

    // random phases with random settings, the last one without idling
    for (int ph = 0; ph < 4; ph++) begin
      cfg_all(20'($urandom), 20'($urandom_range(0, 8192)), 20'($urandom), 20'($urandom),
              20'($urandom), 20'($urandom_range(2000, 40000)),
              20'($urandom_range(2000, 40000)), 20'($urandom_range(1, 6)));
      if (ph == 3) idle_en = 1'b0;
      for (int k = 0; k < 50; k++) send(rand_beat());
      in_valid_i <= 1'b0;
      drain();
    end

    if (mismatches == 0 && report_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
